// ===== rtl/psw_pkg.sv =====
package psw_pkg;

    // Datapath widths
    localparam int ERR_W  = 16;                 // Q8.8 sample width
    localparam int BAND_W = 15;                 // deadband / limit width
    localparam int ACC_W  = 34;                 // Q16.16 PD sum, never wraps
    localparam int WIDE_W = 27;                 // rounded angle plus trim

    localparam logic signed [WIDE_W-1:0] STEP_TENTH = 27'sd26;     // 0.1 in Q8.8
    localparam logic signed [ACC_W-1:0]  ROUND_HALF = 34'sd128;    // 0.5 LSB of Q8.8
    localparam logic [BAND_W-1:0]        ANGLE_MAX  = 15'd25600;   // 100.0 in Q8.8
    localparam logic [BAND_W-1:0]        SPEED_LIMIT_RST = 15'd512;

    typedef enum logic [2:0] {
        REG_GAIN_PROP      = 3'd0,
        REG_GAIN_DERIV     = 3'd1,
        REG_STEER_OFFSET   = 3'd2,
        REG_CRUISE_SPEED   = 3'd3,
        REG_SPEED_DEADBAND = 3'd4,
        REG_ANGLE_DEADBAND = 3'd5,
        REG_SPEED_LIMIT    = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        KEY_UP      = 3'd0,
        KEY_BACK    = 3'd1,
        KEY_STEER_R = 3'd2,
        KEY_STEER_L = 3'd3
    } key_t;

endpackage

// ===== rtl/pd_steering_with_teleop.sv =====
// Channel  | Dir | Handshake         | Payload
// ---------+-----+-------------------+----------------------------------------------
// s_*      | in  | s_tvalid/s_tready | s_tuser: teleop_valid; s_tdata: key, error
// m_*      | out | m_tvalid/m_tready | m_tdata: velocity, steer_angle
// cfg_*    | in  | cfg_we only       | cfg_index selects register, cfg_wdata value
//
// One request per cycle while m_tready is high; an accepted request passes the
// input register, then the result register, which drives m_tvalid. The PD
// multiplies, rounding, trim, teleop step, deadband and clamps lie between them.
// rst_n is asynchronous: it empties both registers, zeroes the stored speed,
// angle and error, and loads the register defaults (speed_limit = 2.0).
// Stalls: the input register holds while the result register is full and
// blocked; s_tready drops only when both are full and m_tready is low.
module pd_steering_with_teleop
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [2:0] key_code, [18:3] track_error, [23:19] zero
    input  logic        s_tuser,    // [0] teleop_valid

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [15:0] velocity, [31:16] steer_angle

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int EW = psw_pkg::ERR_W;
    localparam int BW = psw_pkg::BAND_W;
    localparam int AW = psw_pkg::ACC_W;
    localparam int WW = psw_pkg::WIDE_W;

    // With use_band, raise nonzero values below the band in magnitude to +-band; then clamp to +-lim.
    function automatic logic signed [WW-1:0] shape(
        input logic signed [WW-1:0] v,
        input logic        [BW-1:0] band,
        input logic        [BW-1:0] lim,
        input logic                 use_band
    );
        logic signed [WW-1:0] b;
        logic signed [WW-1:0] l;
        logic signed [WW-1:0] r;
        b = signed'({{(WW-BW){1'b0}}, band});
        l = signed'({{(WW-BW){1'b0}}, lim});
        r = v;
        if (use_band)
        begin
            if (v > 0 && v < b)
                r = b;
            else if (v < 0 && -v < b)
                r = -b;
        end
        if (r > l)
            r = l;
        else if (r < -l)
            r = -l;
        return r;
    endfunction

    // configuration registers
    logic signed [EW-1:0] gain_prop_reg;
    logic signed [EW-1:0] gain_deriv_reg;
    logic signed [EW-1:0] steer_offset_reg;
    logic signed [EW-1:0] cruise_speed_reg;
    logic        [BW-1:0] speed_deadband_reg;
    logic        [BW-1:0] angle_deadband_reg;
    logic        [BW-1:0] speed_limit_reg;

    // controller state
    logic signed [EW-1:0] last_speed_reg, last_speed_next;
    logic signed [EW-1:0] last_angle_reg, last_angle_next;
    logic signed [EW-1:0] last_error_reg, last_error_next;

    // input register
    logic                 in_vld_reg, in_vld_next;
    logic                 in_tel_reg;
    logic [2:0]           in_key_reg;
    logic signed [EW-1:0] in_err_reg;

    // result register
    logic                 out_vld_reg, out_vld_next;
    logic signed [EW-1:0] out_vel_reg, out_vel_next;
    logic signed [EW-1:0] out_ang_reg, out_ang_next;

    logic out_free, in_free;
    logic in_load, out_load;

    logic signed [31:0]   prod_p;
    logic signed [EW:0]   err_diff;
    logic signed [EW+16:0] prod_d;

    logic signed [AW-1:0] acc_sum;
    logic signed [AW-1:0] acc_rnd;
    logic signed [WW-1:0] ang_auto;
    logic signed [WW-1:0] spd_raw, ang_raw;
    logic signed [WW-1:0] spd_fin, ang_fin;

    // flow control
    assign out_free = !out_vld_reg || m_tready;
    assign in_free  = !in_vld_reg || out_free;
    assign s_tready = in_free;

    assign in_load  = s_tvalid && in_free;
    assign out_load = in_vld_reg && out_free;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_ang_reg, out_vel_reg};

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg      <= '0;
            gain_deriv_reg     <= '0;
            steer_offset_reg   <= '0;
            cruise_speed_reg   <= '0;
            speed_deadband_reg <= '0;
            angle_deadband_reg <= '0;
            speed_limit_reg    <= psw_pkg::SPEED_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (psw_pkg::reg_idx_t'(cfg_index))
                psw_pkg::REG_GAIN_PROP:      gain_prop_reg      <= cfg_wdata;
                psw_pkg::REG_GAIN_DERIV:     gain_deriv_reg     <= cfg_wdata;
                psw_pkg::REG_STEER_OFFSET:   steer_offset_reg   <= cfg_wdata;
                psw_pkg::REG_CRUISE_SPEED:   cruise_speed_reg   <= cfg_wdata;
                psw_pkg::REG_SPEED_DEADBAND: speed_deadband_reg <= cfg_wdata[BW-1:0];
                psw_pkg::REG_ANGLE_DEADBAND: angle_deadband_reg <= cfg_wdata[BW-1:0];
                psw_pkg::REG_SPEED_LIMIT:    speed_limit_reg    <= cfg_wdata[BW-1:0];
                default: ;
            endcase
        end
    end

    // PD products against the error of the last automatic request
    assign err_diff = {in_err_reg[EW-1], in_err_reg} - {last_error_reg[EW-1], last_error_reg};
    assign prod_p   = gain_prop_reg * in_err_reg;
    assign prod_d   = gain_deriv_reg * err_diff;

    always_comb
    begin
        last_error_next = last_error_reg;
        if (out_load && !in_tel_reg)
            last_error_next = in_err_reg;
    end

    // round, trim, teleop step, deadband and clamps
    assign acc_sum  = AW'(prod_p) + AW'(prod_d);
    assign acc_rnd  = acc_sum + psw_pkg::ROUND_HALF;
    assign ang_auto = WW'(signed'(acc_rnd[AW-1:8])) + WW'(steer_offset_reg);

    always_comb
    begin
        if (in_tel_reg)
        begin
            spd_raw = WW'(last_speed_reg);
            ang_raw = WW'(last_angle_reg);
            case (in_key_reg)
                psw_pkg::KEY_UP:      spd_raw = spd_raw + psw_pkg::STEP_TENTH;
                psw_pkg::KEY_BACK:    spd_raw = spd_raw - psw_pkg::STEP_TENTH;
                psw_pkg::KEY_STEER_R: ang_raw = ang_raw + psw_pkg::STEP_TENTH;
                psw_pkg::KEY_STEER_L: ang_raw = ang_raw - psw_pkg::STEP_TENTH;
                default:
                begin
                    spd_raw = '0;
                    ang_raw = '0;
                end
            endcase
        end
        else
        begin
            spd_raw = WW'(cruise_speed_reg);
            ang_raw = ang_auto;
        end
        spd_fin = shape(spd_raw, speed_deadband_reg, speed_limit_reg, !in_tel_reg);
        ang_fin = shape(ang_raw, angle_deadband_reg, psw_pkg::ANGLE_MAX, !in_tel_reg);

        out_vel_next    = out_load ? spd_fin[EW-1:0] : out_vel_reg;
        out_ang_next    = out_load ? ang_fin[EW-1:0] : out_ang_reg;
        last_speed_next = out_load ? spd_fin[EW-1:0] : last_speed_reg;
        last_angle_next = out_load ? ang_fin[EW-1:0] : last_angle_reg;
    end

    // valid bits
    always_comb
    begin
        in_vld_next  = in_load  || (in_vld_reg  && !out_free);
        out_vld_next = out_load || (out_vld_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            last_speed_reg <= '0;
            last_angle_reg <= '0;
            last_error_reg <= '0;
        end
        else
        begin
            in_vld_reg     <= in_vld_next;
            out_vld_reg    <= out_vld_next;
            last_speed_reg <= last_speed_next;
            last_angle_reg <= last_angle_next;
            last_error_reg <= last_error_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_tel_reg <= s_tuser;
            in_key_reg <= s_tdata[2:0];
            in_err_reg <= s_tdata[18:3];
        end
        out_vel_reg <= out_vel_next;
        out_ang_reg <= out_ang_next;
    end

endmodule

// ===== rtl/psw_checker.sv =====
module psw_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // nothing leaves while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid during reset");

    // steering angle always inside +-100.0
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[31:16]) <= $signed({1'b0, psw_pkg::ANGLE_MAX}) &&
                      $signed(m_tdata[31:16]) >= -$signed({1'b0, psw_pkg::ANGLE_MAX})))
        else $error("steer_angle outside clamp");

    // a draining output never blocks the input side
    a_ready_pass: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

endmodule

bind pd_steering_with_teleop psw_checker u_psw_checker (.*);
